@@ hdl/sia_pkg.sv @@
// Shared types, widths and codes for the sorted insertion array.
package sia_pkg;

	// Storage geometry.
	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = $clog2(DEPTH);

	// The read path ORs the cells in groups, one registered word per group.
	localparam int GROUP  = 8;
	localparam int NGRP   = DEPTH / GROUP;

	// Stream widths, padded to whole bytes.
	localparam int IN_W   = 40;
	localparam int OUT_W  = 48;

	typedef logic [DATA_W-1:0] data_t;

	// Request modes as they arrive on the input stream.
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_READ   = 2'd1,
		MODE_REMOVE = 2'd2
	} sia_mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} sia_stat_t;

	// What every cell does in the current cycle.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} sia_op_t;

	// Command broadcast to the row of cells.
	typedef struct packed {
		sia_op_t            op;
		data_t              value;
		logic [IDX_W-1:0]   idx;
		logic [CNT_W-1:0]   count;
	} sia_cmd_t;

endpackage

@@ hdl/sorted_insert_array_core.sv @@
// Top level of the sorted insertion array: request sequencing, row of cells and read path.
//
// The block keeps up to 64 unsigned 32-bit values in ascending order in a row of
// cells that all compare and shift in the same cycle. A request passes through the idle
// state, in which it is accepted; the execute state, in which every cell compares and
// shifts while the read path registers one partial OR per group of eight cells; and the
// finish state, in which the partial words are combined into the result register, and
// which holds while the previous result waits unaccepted on the output. A new request is
// taken once the result loads, even while that result still waits on the output. Insert
// lands ahead of equal values; an insert into a full store is refused with status 2; a
// read or remove at an index at or above the element count returns all ones with status
// 1 and changes nothing. Stored values need no clearing after reset, since only entries
// below the count are read.
module sorted_insert_array_core import sia_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // mode[1:0], value[33:2], index[39:34]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // read_value[31:0], status[33:32], count[40:34], zero pad
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] res_cnt_q;
	sia_op_t          req_op_q;
	sia_stat_t        req_stat_q;
	logic             req_sel_q;
	data_t            req_value_q;
	logic [IDX_W-1:0] req_idx_q;
	data_t            grp_q [NGRP];
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	sia_cmd_t         cmd;
	data_t            cell_data [DEPTH];
	logic             cell_lt [DEPTH];
	data_t            grp_d [NGRP];
	data_t            tree_or;
	data_t            res_value;
	logic             res_load;

	// Request fields.
	sia_mode_t        in_mode;
	data_t            in_value;
	logic [IDX_W-1:0] in_idx;
	logic             in_range;
	logic             accept;

	assign in_mode  = sia_mode_t'(s_tdata[1:0]);
	assign in_value = s_tdata[33:2];
	assign in_idx   = s_tdata[39:34];
	assign in_range = CNT_W'(in_idx) < count_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Cells only act during the execute cycle.
	always_comb begin
		cmd.op    = (state_q == ST_EXEC) ? req_op_q : CELL_HOLD;
		cmd.value = req_value_q;
		cmd.idx   = req_idx_q;
		cmd.count = count_q;
	end

	// The row of cells; the ends see a virtual smaller neighbor below and zero above.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		data_t prev_d;
		logic  prev_l;
		data_t next_d;

		if (i == 0) begin : g_first
			assign prev_d = '0;
			assign prev_l = 1'b1;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
			assign prev_l = cell_lt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end

		sia_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.pos       (POS_W'(i)),
			.prev_data (prev_d),
			.prev_lt   (prev_l),
			.next_data (next_d),
			.data      (cell_data[i]),
			.lt        (cell_lt[i])
		);
	end

	// First level of the read path: each group ORs the cell that matches the index.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (CNT_W'(g * GROUP + k) == CNT_W'(req_idx_q)) begin
					grp_d[g] = grp_d[g] | cell_data[g * GROUP + k];
				end
			end
		end
	end

	// Second level: combine the registered group words.
	always_comb begin
		tree_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			tree_or = tree_or | grp_q[g];
		end
	end

	// Group words are captured once, before the cells shift, and held until the result loads.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_q[g] <= grp_d[g];
			end
		end
	end

	// Result word and the condition for loading it into the output register.
	assign res_value = req_sel_q ? tree_or : ((req_stat_q == STAT_RANGE) ? '1 : '0);
	assign res_load  = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// Request sequencer with count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_cnt_q   <= '0;
			req_op_q    <= CELL_HOLD;
			req_stat_q  <= STAT_OK;
			req_sel_q   <= 1'b0;
			req_value_q <= '0;
			req_idx_q   <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// The output is valid from the load until the result is taken.
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_value_q <= in_value;
						req_idx_q   <= in_idx;
						req_op_q    <= CELL_HOLD;
						req_stat_q  <= STAT_OK;
						req_sel_q   <= 1'b0;
						case (in_mode)
							MODE_INSERT: begin
								if (count_q >= CNT_W'(DEPTH)) begin
									req_stat_q <= STAT_FULL;
								end else begin
									req_op_q <= CELL_INSERT;
								end
							end
							MODE_READ: begin
								if (in_range) begin
									req_sel_q <= 1'b1;
								end else begin
									req_stat_q <= STAT_RANGE;
								end
							end
							MODE_REMOVE: begin
								if (in_range) begin
									req_sel_q <= 1'b1;
									req_op_q  <= CELL_REMOVE;
								end else begin
									req_stat_q <= STAT_RANGE;
								end
							end
							default: begin
							end
						endcase
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (req_op_q)
						CELL_INSERT: begin
							count_q   <= count_q + 1'b1;
							res_cnt_q <= count_q + 1'b1;
						end
						CELL_REMOVE: begin
							count_q   <= count_q - 1'b1;
							res_cnt_q <= count_q - 1'b1;
						end
						default: begin
							res_cnt_q <= count_q;
						end
					endcase
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_load) begin
						m_tdata_q <= OUT_W'({7'(res_cnt_q), req_stat_q, res_value});
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The element count never exceeds the row length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	// An accepted insert grows the count by exactly one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && req_op_q == CELL_INSERT) |=>
		count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("insert did not grow the count");

	// A refused insert never reaches the cells.
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req_stat_q == STAT_FULL) |-> req_op_q == CELL_HOLD)
		else $error("refused insert issued to cells");

	// A new result is only loaded from the finishing cycle.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside finishing cycle");

endmodule

@@ hdl/sia_cell.sv @@
// One storage cell of the sorted row: holds an element and trades it with its neighbors.
module sia_cell import sia_pkg::*; (
	input  logic             clk,
	input  sia_cmd_t         cmd,
	input  logic [POS_W-1:0] pos,
	input  data_t            prev_data,
	input  logic             prev_lt,
	input  data_t            next_data,
	output data_t            data,
	output logic             lt
);

	data_t data_q;
	logic  occupied;

	assign data = data_q;

	// A cell is occupied when its position lies below the element count.
	assign occupied = CNT_W'(pos) < cmd.count;

	// Stored element is strictly less than the value being inserted.
	assign lt = occupied && (data_q < cmd.value);

	// Insert: cells below the insertion point hold, the cell at it takes the new
	// value, the cells above it take their lower neighbor. Remove: cells at or
	// above the index take their upper neighbor.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (!lt) begin
					data_q <= prev_lt ? cmd.value : prev_data;
				end
			end
			CELL_REMOVE: begin
				if (CNT_W'(pos) >= CNT_W'(cmd.idx)) begin
					data_q <= next_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
